@@ design/assert_macros.svh @@
// Assertion helpers used by radix2_fft_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with active-low reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, with no reset disable.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/r2fft_pkg.sv @@
// ----------------------------------------------------------------------------
// r2fft_pkg
// Constants, types and twiddle table for the radix-2 DIT FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

    localparam int FRAME_LEN = 32;
    localparam int LOG2_LEN  = $clog2(FRAME_LEN);
    localparam int AW        = LOG2_LEN;
    localparam int SW        = LOG2_LEN + 1;
    localparam int IN_W      = 16;
    localparam int DW        = 27;
    localparam int TW_W      = 16;
    localparam int TW_FULL   = 64;

    typedef logic signed [DW-1:0]   t_data;
    typedef logic signed [TW_W-1:0] t_tw;
    typedef logic [AW-1:0]          t_addr;

    typedef struct packed {
        logic  wr_en;
        t_addr wr_addr;
        t_data wr_re;
        t_data wr_im;
    } t_mem_wr;

    function automatic t_tw quarter_cos(input logic [4:0] j);
        t_tw v;
        begin
            unique case (j)
                5'd0:  v = 16'sd32767;
                5'd1:  v = 16'sd32610;
                5'd2:  v = 16'sd32138;
                5'd3:  v = 16'sd31357;
                5'd4:  v = 16'sd30274;
                5'd5:  v = 16'sd28899;
                5'd6:  v = 16'sd27246;
                5'd7:  v = 16'sd25330;
                5'd8:  v = 16'sd23170;
                5'd9:  v = 16'sd20788;
                5'd10: v = 16'sd18205;
                5'd11: v = 16'sd15447;
                5'd12: v = 16'sd12540;
                5'd13: v = 16'sd9512;
                5'd14: v = 16'sd6393;
                5'd15: v = 16'sd3212;
                default: v = 16'sd0;
            endcase
            return v;
        end
    endfunction

    // cos / sin of 2*pi*j/64, j in 0..31
    function automatic logic [2*TW_W-1:0] twiddle(input logic [4:0] j);
        t_tw c;
        t_tw s;
        begin
            if (j <= 5'd16) begin
                c = quarter_cos(j);
                s = quarter_cos(5'd16 - j);
            end else begin
                c = -quarter_cos(5'd0 - j);
                s = quarter_cos(j - 5'd16);
            end
            return {c, s};
        end
    endfunction

    function automatic t_addr bit_rev(input t_addr v);
        t_addr r;
        begin
            for (int i = 0; i < AW; i++) begin
                r[i] = v[AW-1-i];
            end
            return r;
        end
    endfunction

endpackage

@@ design/r2fft_if.sv @@
// ----------------------------------------------------------------------------
// r2fft_in_if / r2fft_out_if
// Valid/ready request channels for samples and bins.
// ----------------------------------------------------------------------------
interface r2fft_in_if;
    logic                         valid;
    logic                         ready;
    logic signed [15:0]           sample_re;
    logic signed [15:0]           sample_im;
    logic                         frame_end;
    modport source (output valid, sample_re, sample_im, frame_end, input ready);
    modport sink   (input valid, sample_re, sample_im, frame_end, output ready);
endinterface

interface r2fft_out_if;
    logic                         valid;
    logic                         ready;
    logic signed [26:0]           bin_re;
    logic signed [26:0]           bin_im;
    logic                         bin_last;
    modport source (output valid, bin_re, bin_im, bin_last, input ready);
    modport sink   (input valid, bin_re, bin_im, bin_last, output ready);
endinterface

@@ design/r2fft_ram.sv @@
// ----------------------------------------------------------------------------
// r2fft_ram
// Frame buffer: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module r2fft_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 54
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

@@ design/r2fft_bfly.sv @@
// ----------------------------------------------------------------------------
// r2fft_bfly
// Two-stage butterfly: registered products, then round, add and subtract.
// ----------------------------------------------------------------------------
module r2fft_bfly (
    input  logic                   i_clk,
    input  r2fft_pkg::t_data       i_ar,
    input  r2fft_pkg::t_data       i_ai,
    input  r2fft_pkg::t_data       i_br,
    input  r2fft_pkg::t_data       i_bi,
    input  r2fft_pkg::t_tw         i_c,
    input  r2fft_pkg::t_tw         i_s,
    output r2fft_pkg::t_data       o_xr,
    output r2fft_pkg::t_data       o_xi,
    output r2fft_pkg::t_data       o_yr,
    output r2fft_pkg::t_data       o_yi
);
    logic signed [42:0] r_cbr, r_sbi, r_cbi, r_sbr;
    r2fft_pkg::t_data   r_ar, r_ai;
    logic signed [44:0] pr, pi;
    r2fft_pkg::t_data   tr, ti;

    always_ff @(posedge i_clk) begin
        r_cbr <= 43'(i_c * i_br);
        r_sbi <= 43'(i_s * i_bi);
        r_cbi <= 43'(i_c * i_bi);
        r_sbr <= 43'(i_s * i_br);
        r_ar  <= i_ar;
        r_ai  <= i_ai;
    end

    // floor((p + 2^14) / 2^15)
    always_comb begin
        pr = 45'(r_cbr) + 45'(r_sbi) + 45'sd16384;
        pi = 45'(r_cbi) - 45'(r_sbr) + 45'sd16384;
        tr = r2fft_pkg::t_data'(pr >>> 15);
        ti = r2fft_pkg::t_data'(pi >>> 15);
        o_xr = r_ar + tr;
        o_xi = r_ai + ti;
        o_yr = r_ar - tr;
        o_yi = r_ai - ti;
    end
endmodule

@@ design/radix2_fft_top.sv @@
// Sequence: after the sample that ends a frame, the rest of the frame is zero-filled, then
//   each butterfly steps through ST_RD, ST_MUL, ST_WA and ST_WB, then the bins are read out.
// Throughput: one sample per cycle while loading, one bin per cycle when taken; input
//   is held off during zero-fill, the transform and until the last bin of the frame leaves.
// Reset: synchronous active-low, clears the load counter and control state;
//   frame buffer contents stay undefined until written.
// ----------------------------------------------------------------------------
// radix2_fft_top
// Radix-2 DIT FFT around one frame buffer: load, in-place stages, bin readout.
// ----------------------------------------------------------------------------
module radix2_fft_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    r2fft_in_if.sink        i_in,
    r2fft_out_if.source     o_out
);
    `include "assert_macros.svh"

    localparam int N  = r2fft_pkg::FRAME_LEN;
    localparam int AW = r2fft_pkg::AW;
    localparam int SW = r2fft_pkg::SW;

    typedef enum logic [2:0] {
        ST_LOAD, ST_PAD, ST_RD, ST_MUL, ST_WA, ST_WB, ST_OUT
    } t_state;

    t_state              r_state;
    logic [SW-1:0]       r_cnt;
    logic [AW-1:0]       r_stage;
    logic [AW-1:0]       r_bf;
    r2fft_pkg::t_data    r_yr, r_yi;
    logic [SW-1:0]       r_ocnt;
    logic                r_rd_pend;

    logic [AW-1:0]       half, kk, ia, ib, tw_j;
    logic [2*r2fft_pkg::TW_W-1:0] tw;
    r2fft_pkg::t_mem_wr  wr;
    logic [AW-1:0]       ra_a, ra_b;
    logic [2*r2fft_pkg::DW-1:0] rd_a, rd_b;
    r2fft_pkg::t_data    xr, xi, yr, yi;
    logic                acc_in, acc_out;
    logic [AW-1:0]       in_pos;

    assign acc_in  = i_in.valid & i_in.ready;
    assign acc_out = o_out.valid & o_out.ready;
    assign i_in.ready = (r_state == ST_LOAD);
    assign in_pos = r_cnt[AW-1:0];

    // butterfly addressing: stage s, butterfly index j
    always_comb begin
        half = AW'(1) << r_stage;
        kk   = r_bf & (half - AW'(1));
        ia   = ((r_bf & ~(half - AW'(1))) << 1) | kk;
        ib   = ia | half;
        tw_j = AW'(kk << (AW - 1 - r_stage));
        tw   = r2fft_pkg::twiddle(5'((32'(tw_j) * (r2fft_pkg::TW_FULL / N)) & 31));
    end

    always_comb begin
        wr = '0;
        ra_a = ia;
        ra_b = ib;
        unique case (r_state)
            ST_LOAD: begin
                wr.wr_en   = acc_in;
                wr.wr_addr = r2fft_pkg::bit_rev(in_pos);
                wr.wr_re   = r2fft_pkg::t_data'(i_in.sample_re);
                wr.wr_im   = r2fft_pkg::t_data'(i_in.sample_im);
            end
            ST_PAD: begin
                wr.wr_en   = 1'b1;
                wr.wr_addr = r2fft_pkg::bit_rev(in_pos);
            end
            ST_WA: begin
                wr.wr_en = 1'b1; wr.wr_addr = ia; wr.wr_re = xr; wr.wr_im = xi;
            end
            ST_WB: begin
                wr.wr_en = 1'b1; wr.wr_addr = ib; wr.wr_re = r_yr; wr.wr_im = r_yi;
            end
            ST_OUT: begin
                // advance reads the next bin, a stall re-reads the bin waiting in rd_a
                ra_a = ((acc_out || !o_out.valid) && !r_rd_pend) ? r_ocnt[AW-1:0]
                                                                 : AW'(r_ocnt[AW-1:0] - AW'(1));
            end
            default: ;
        endcase
    end

    r2fft_ram #(.DEPTH(N), .WIDTH(2*r2fft_pkg::DW)) u_ram (
        .i_clk    (i_clk),
        .i_we     (wr.wr_en),
        .i_waddr  (wr.wr_addr),
        .i_wdata  ({wr.wr_re, wr.wr_im}),
        .i_raddr_a(ra_a),
        .i_raddr_b(ra_b),
        .o_rdata_a(rd_a),
        .o_rdata_b(rd_b)
    );

    r2fft_bfly u_bfly (
        .i_clk(i_clk),
        .i_ar (rd_a[2*r2fft_pkg::DW-1:r2fft_pkg::DW]),
        .i_ai (rd_a[r2fft_pkg::DW-1:0]),
        .i_br (rd_b[2*r2fft_pkg::DW-1:r2fft_pkg::DW]),
        .i_bi (rd_b[r2fft_pkg::DW-1:0]),
        .i_c  (tw[2*r2fft_pkg::TW_W-1:r2fft_pkg::TW_W]),
        .i_s  (tw[r2fft_pkg::TW_W-1:0]),
        .o_xr (xr), .o_xi(xi), .o_yr(yr), .o_yi(yi)
    );

    // output: rd_a holds bin r_ocnt-1 in the cycle after its read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_cnt     <= '0;
            r_stage   <= '0;
            r_bf      <= '0;
            r_ocnt    <= '0;
            r_rd_pend <= 1'b0;
            o_out.valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (acc_in) begin
                        if (i_in.frame_end || in_pos == AW'(N - 1)) begin
                            r_state <= (in_pos == AW'(N - 1)) ? ST_RD : ST_PAD;
                            r_cnt   <= SW'(r_cnt + 1'b1);
                            r_stage <= '0;
                            r_bf    <= '0;
                        end else begin
                            r_cnt <= SW'(r_cnt + 1'b1);
                        end
                    end
                end
                ST_PAD: begin
                    r_cnt <= SW'(r_cnt + 1'b1);
                    if (in_pos == AW'(N - 1)) begin
                        r_state <= ST_RD;
                    end
                end
                ST_RD:  r_state <= ST_MUL;
                ST_MUL: r_state <= ST_WA;
                ST_WA: begin
                    r_yr <= yr;
                    r_yi <= yi;
                    r_state <= ST_WB;
                end
                ST_WB: begin
                    if (r_bf == AW'(N / 2 - 1)) begin
                        r_bf <= '0;
                        if (r_stage == AW'(AW - 1)) begin
                            r_state   <= ST_OUT;
                            r_ocnt    <= SW'(1);
                            r_rd_pend <= 1'b1;
                        end else begin
                            r_stage <= AW'(r_stage + 1'b1);
                            r_state <= ST_RD;
                        end
                    end else begin
                        r_bf    <= AW'(r_bf + 1'b1);
                        r_state <= ST_RD;
                    end
                end
                ST_OUT: begin
                    if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                    end else if (acc_out || !o_out.valid) begin
                        if (r_ocnt == SW'(N + 1)) begin
                            o_out.valid <= 1'b0;
                            r_state     <= ST_LOAD;
                            r_cnt       <= '0;
                        end else begin
                            o_out.valid    <= 1'b1;
                            o_out.bin_re   <= rd_a[2*r2fft_pkg::DW-1:r2fft_pkg::DW];
                            o_out.bin_im   <= rd_a[r2fft_pkg::DW-1:0];
                            o_out.bin_last <= (r_ocnt == SW'(N));
                            r_ocnt         <= SW'(r_ocnt + 1'b1);
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    `ASSERT_CLK(a_no_load_busy, i_clk, i_rst_n,
        (r_state != ST_LOAD) |-> !i_in.ready, "input ready outside load")
    `ASSERT_CLK(a_out_only_out, i_clk, i_rst_n,
        o_out.valid |-> (r_state == ST_OUT), "bin valid outside output phase")
    `ASSERT_CLK(a_last_ends, i_clk, i_rst_n,
        (acc_out && o_out.bin_last) |=> !o_out.valid, "bin after last bin")
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the radix-2 FFT frame by frame: samples go in through the request
// channel, a fixed-point transform model predicts every bin, and each bin
// that leaves the block is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;
    localparam int FRAME_LEN    = r2fft_pkg::FRAME_LEN;
    localparam int LOG2_LEN     = r2fft_pkg::LOG2_LEN;
    localparam int TW_FULL      = r2fft_pkg::TW_FULL;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 600;
    localparam int FLUSH_CYCLES = 5 * (FRAME_LEN / 2) * LOG2_LEN + FRAME_LEN + 50;

    typedef r2fft_pkg::t_data t_data;

    typedef struct packed {
        t_data re;
        t_data im;
        logic  last;
    } t_bin;

    logic i_clk;
    logic i_rst_n;

    r2fft_in_if  in_ch ();
    r2fft_out_if out_ch ();

    radix2_fft_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    longint frame_re [FRAME_LEN];
    longint frame_im [FRAME_LEN];
    int     load_pos;
    t_bin   bin_queue [$];
    int     n_errors;
    int     n_samples;
    int     n_bins;
    int     n_frames;
    int     cycle_count;
    int     hold_cycles;
    bit     hold_enable;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[radix2_fft_top] ERROR");
            $finish;
        end
    end

    function automatic longint round_q15(input longint p);
        longint x;
        x = p + 16384;
        if (x >= 0) return x >>> 15;
        return -((-x + 32767) >>> 15);
    endfunction

    function automatic void twiddle_q15(input int j, output longint c, output longint s);
        longint tbl [17] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                             23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
        j = j & 31;
        if (j <= 16) begin
            c = tbl[j];
            s = tbl[16 - j];
        end else begin
            c = -tbl[32 - j];
            s = tbl[j - 16];
        end
    endfunction

    task automatic predict_bins();
        longint wr [FRAME_LEN];
        longint wi [FRAME_LEN];
        longint c, s, tr, ti, ar, ai, br, bi;
        int r, h, ia, ib;
        t_bin b;
        for (int i = 0; i < FRAME_LEN; i++) begin
            r = 0;
            for (int k = 0; k < LOG2_LEN; k++) r = (r << 1) | ((i >> k) & 1);
            wr[r] = frame_re[i];
            wi[r] = frame_im[i];
        end
        for (int m = 2; m <= FRAME_LEN; m = m << 1) begin
            h = m >> 1;
            for (int base = 0; base < FRAME_LEN; base += m) begin
                for (int k = 0; k < h; k++) begin
                    ia = base + k;
                    ib = base + k + h;
                    twiddle_q15(k * (TW_FULL / m), c, s);
                    ar = wr[ia]; ai = wi[ia];
                    br = wr[ib]; bi = wi[ib];
                    tr = round_q15(c * br + s * bi);
                    ti = round_q15(c * bi - s * br);
                    wr[ia] = ar + tr; wi[ia] = ai + ti;
                    wr[ib] = ar - tr; wi[ib] = ai - ti;
                end
            end
        end
        for (int i = 0; i < FRAME_LEN; i++) begin
            b.re   = t_data'(wr[i]);
            b.im   = t_data'(wi[i]);
            b.last = (i == FRAME_LEN - 1);
            bin_queue.push_back(b);
        end
        n_frames++;
    endtask

    task automatic load_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                               input logic fe);
        frame_re[load_pos] = re;
        frame_im[load_pos] = im;
        if (fe || load_pos == FRAME_LEN - 1) begin
            for (int i = load_pos + 1; i < FRAME_LEN; i++) begin
                frame_re[i] = 0;
                frame_im[i] = 0;
            end
            predict_bins();
            load_pos = 0;
        end else begin
            load_pos++;
        end
    endtask

    // valid stays high after a request so that the next one can follow at once
    task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                               input logic fe, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_re <= re;
        in_ch.sample_im <= im;
        in_ch.frame_end <= fe;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        load_sample(re, im, fe);
        n_samples++;
    endtask

    task automatic end_input();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_rand(input logic signed [15:0] re, input logic signed [15:0] im,
                             input logic fe);
        send_sample(re, im, fe, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11));
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 4))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return $signed(16'($urandom_range(0, 255)) - 16'sd128);
            default: return $signed(16'($urandom));
        endcase
    endfunction

    // bins leave the block as accepted; compared field by field against the queue
    always @(posedge i_clk) begin
        t_bin e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_bins++;
            if (bin_queue.size() == 0) begin
                $error("bin with no expectation: re=%0d im=%0d", out_ch.bin_re, out_ch.bin_im);
                n_errors++;
            end else begin
                e = bin_queue.pop_front();
                if (out_ch.bin_re !== e.re) begin
                    $error("bin_re expected %0d actual %0d", e.re, out_ch.bin_re);
                    n_errors++;
                end
                if (out_ch.bin_im !== e.im) begin
                    $error("bin_im expected %0d actual %0d", e.im, out_ch.bin_im);
                    n_errors++;
                end
                if (out_ch.bin_last !== e.last) begin
                    $error("bin_last expected %0d actual %0d", e.last, out_ch.bin_last);
                    n_errors++;
                end
            end
        end
    end

    // receiver stalls: random per bin, or a long hold-off counted here
    initial begin
        int wait_n;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_enable) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(posedge i_clk);
                    hold_cycles++;
                end
                hold_enable = 1'b0;
            end else if (out_ch.ready && out_ch.valid) begin
                wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
                if (wait_n != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (wait_n) @(posedge i_clk);
                    out_ch.ready <= 1'b1;
                end
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic test_extremes();
        send_rand(16'sh7fff, 16'sh7fff, 1'b0);
        send_rand(16'sh8000, 16'sh8000, 1'b0);
        for (int i = 2; i < FRAME_LEN; i++)
            send_rand((i % 2) ? 16'sh8000 : 16'sh7fff, (i % 2) ? 16'sh7fff : 16'sh8000,
                      i == FRAME_LEN - 1);
    endtask

    task automatic test_short_frames();
        send_rand(16'sh7fff, 16'sh8000, 1'b1);
        send_rand(16'sd1, -16'sd1, 1'b0);
        send_rand(-16'sd1, 16'sd1, 1'b1);
    endtask

    task automatic test_overlong_frame();
        for (int i = 0; i < FRAME_LEN; i++) send_rand(rand_sample(), rand_sample(), 1'b0);
        send_rand(16'sd100, -16'sd100, 1'b1);
    endtask

    task automatic test_backpressure();
        hold_enable = 1'b1;
        for (int i = 0; i < FRAME_LEN + 4; i++)
            send_sample(rand_sample(), rand_sample(), (i % FRAME_LEN) == FRAME_LEN - 1, 0);
        end_input();
        wait (!hold_enable);
    endtask

    task automatic test_random_frames();
        int len;
        int sent;
        sent = 0;
        while (sent < 66) begin
            case ($urandom_range(0, 5))
                0: len = $urandom_range(1, 6);
                1: len = FRAME_LEN + $urandom_range(1, 3);
                default: len = FRAME_LEN;
            endcase
            for (int i = 0; i < len; i++) begin
                send_rand(rand_sample(), rand_sample(), i == len - 1);
                sent++;
            end
        end
        end_input();
    endtask

    initial begin
        n_errors    = 0;
        n_samples   = 0;
        n_bins      = 0;
        n_frames    = 0;
        cycle_count = 0;
        hold_cycles = 0;
        hold_enable = 1'b0;
        load_pos    = 0;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.sample_re <= '0;
        in_ch.sample_im <= '0;
        in_ch.frame_end <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_short_frames();
        test_overlong_frame();
        test_backpressure();
        test_random_frames();

        while (bin_queue.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);

        $display("%0d samples sent, %0d frames transformed, %0d bins checked",
                 n_samples, n_frames, n_bins);
        $display("covered full-scale, zero-padded, overlong and stalled frames");
        if (n_errors == 0) begin
            $display("[radix2_fft_top] OK");
        end else begin
            $display("[radix2_fft_top] ERROR");
        end
        $finish;
    end

endmodule

@@ radix2_fft_top.f @@
+incdir+design
design/r2fft_pkg.sv
design/r2fft_if.sv
design/r2fft_ram.sv
design/r2fft_bfly.sv
design/radix2_fft_top.sv
sim/tb_top.sv
